// File: rtl/gamm_pkg.sv
`timescale 1ns / 1ps

package gamm_pkg;

    // upper rom slots fitted
    localparam int ROM_SLOTS_DEFAULT = 16;

    localparam int PAGE_BITS   = 14;
    localparam int OFFSET_BITS = 20;

    // pen 16 is the border
    localparam logic [4:0] BORDER_PEN = 5'd16;

    // reset value of rom/mode bits 3..0: mode 1, upper rom disabled
    localparam logic [3:0] ROM_MODE_RESET = 4'h9;

    typedef enum logic [1:0] {
        FUNC_GA_WRITE = 2'd0,
        FUNC_ROM_SEL  = 2'd1,
        FUNC_MEM      = 2'd2,
        FUNC_TICK     = 2'd3
    } t_func;

    // gate array command, data bits 7..6
    typedef enum logic [1:0] {
        GA_PEN    = 2'd0,
        GA_COLOUR = 2'd1,
        GA_MODE   = 2'd2,
        GA_RAM    = 2'd3
    } t_ga_cmd;

    typedef enum logic [2:0] {
        SRC_RAM       = 3'd0,
        SRC_LOWER_ROM = 3'd1,
        SRC_UPPER_ROM = 3'd2,
        SRC_EXTRA_ROM = 3'd3,
        SRC_ASIC_PAGE = 3'd4
    } t_source;

    typedef enum logic [1:0] {
        REG_RAM_EXPANSION = 2'd0,
        REG_PLUS_MODEL    = 2'd1,
        REG_ASIC_UNLOCKED = 2'd2,
        REG_EXTRA_ROM     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_func       func;
        logic [7:0]  data;
        logic [15:0] cpu_addr;
        logic        is_write;
    } t_in_item;

    typedef struct packed {
        t_source                  source;
        logic [OFFSET_BITS-1:0]   phys_offset;
        logic [3:0]               rom_slot;
        logic [1:0]               screen_mode;
        logic                     irq_clear;
        logic                     ink_write;
        logic [4:0]               ink_pen;
        logic [4:0]               ink_colour;
    } t_result;

    // bank used by each page (row) for each ram configuration (column)
    localparam logic [2:0] BANK_MAP [4][8] = '{
        '{3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd1, 3'd5, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd2, 3'd2, 3'd6, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
        '{3'd3, 3'd7, 3'd7, 3'd7, 3'd3, 3'd3, 3'd3, 3'd3}
    };

endpackage

// File: rtl/gate_array_memory_mapper_unit.sv
`timescale 1ns / 1ps

// Gate array register decode and memory banking. Each input transaction is a
// gate array write, an upper rom select, a memory access or a colour tick, and
// gives exactly one result transaction: the source and offset of the access,
// the current upper rom slot and screen mode, an interrupt-clear pulse on mode
// writes, and the pen/colour committed on a tick. A transaction is captured in
// an input register and decoded from there into the result register; one
// transaction is taken every cycle, and the block only stalls when the result
// register is full and not being taken. Banking and rom enables apply to the
// very next transaction; the slot and screen mode of a result already show
// its own write. The configuration port is always ready; it must be written
// only while the block is idle, which the block itself does not enforce.
module gate_array_memory_mapper_unit #(
    parameter int ROM_SLOTS = gamm_pkg::ROM_SLOTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transactions
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  gamm_pkg::t_in_item    i_in_item,
    // result transactions
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output gamm_pkg::t_result     o_out_result,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [1:0]            i_cfg_data
);
    import gamm_pkg::*;

    // slot numbers at or above this read as slot 0
    localparam logic [8:0] SLOT_LIMIT = 9'(ROM_SLOTS);

    // configuration
    logic [1:0] r_ram_expansion;
    logic       r_plus_model;
    logic       r_asic_unlocked;
    logic       r_extra_rom;

    // gate array state
    logic [4:0] r_pen_select,   n_pen_select;
    logic       r_pending_valid, n_pending_valid;
    logic [4:0] r_pending_colour, n_pending_colour;
    logic [3:0] r_rom_mode,     n_rom_mode;
    logic [2:0] r_ram_config,   n_ram_config;
    logic [2:0] r_ram_block,    n_ram_block;
    logic       r_asic_page_on, n_asic_page_on;
    logic [7:0] r_upper_rom_sel, n_upper_rom_sel;

    // pipeline
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_result    r_out,          n_out;
    logic       advance;

    // decode helpers
    t_ga_cmd     ga_cmd;
    logic [1:0]  page;
    logic [PAGE_BITS-1:0] page_addr;
    logic [2:0]  bank;
    logic [OFFSET_BITS-1:0] ram_offset;
    logic [OFFSET_BITS-1:0] rom_offset;
    logic [3:0]  block_plus_one;
    logic        lo_off;
    logic        hi_off;

    // stage 2 moves when the result register is free or being emptied
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_result = r_out;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_expansion <= 2'd0;
            r_plus_model    <= 1'b0;
            r_asic_unlocked <= 1'b0;
            r_extra_rom     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                REG_RAM_EXPANSION: r_ram_expansion <= i_cfg_data;
                REG_PLUS_MODEL:    r_plus_model    <= i_cfg_data[0];
                REG_ASIC_UNLOCKED: r_asic_unlocked <= i_cfg_data[0];
                REG_EXTRA_ROM:     r_extra_rom     <= i_cfg_data[0];
                default:           r_extra_rom     <= r_extra_rom;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // address mapping, driven from state as it stands before this transaction
    always_comb begin
        page           = r_in.cpu_addr[15:14];
        page_addr      = r_in.cpu_addr[PAGE_BITS-1:0];
        bank           = BANK_MAP[page][r_ram_config];
        block_plus_one = {1'b0, r_ram_block} + 4'd1;
        lo_off         = r_rom_mode[2];
        hi_off         = r_rom_mode[3];
        rom_offset     = {{(OFFSET_BITS-PAGE_BITS){1'b0}}, page_addr};
        if (bank[2]) begin
            // extended ram: 64K block above the base, then 16K bank
            ram_offset = {block_plus_one, bank[1:0], page_addr};
        end else begin
            ram_offset = {4'd0, bank[1:0], page_addr};
        end
    end

    // state update and result
    always_comb begin
        ga_cmd           = t_ga_cmd'(r_in.data[7:6]);
        n_pen_select     = r_pen_select;
        n_pending_valid  = r_pending_valid;
        n_pending_colour = r_pending_colour;
        n_rom_mode       = r_rom_mode;
        n_ram_config     = r_ram_config;
        n_ram_block      = r_ram_block;
        n_asic_page_on   = r_asic_page_on;
        n_upper_rom_sel  = r_upper_rom_sel;

        n_out             = '0;
        n_out.source      = SRC_RAM;

        case (r_in.func)
            FUNC_GA_WRITE: begin
                case (ga_cmd)
                    GA_PEN: begin
                        // values above the border clamp to the border
                        if (r_in.data[4:0] > BORDER_PEN) begin
                            n_pen_select = BORDER_PEN;
                        end else begin
                            n_pen_select = r_in.data[4:0];
                        end
                    end
                    GA_COLOUR: begin
                        n_pending_valid  = 1'b1;
                        n_pending_colour = r_in.data[4:0];
                    end
                    GA_MODE: begin
                        if (r_in.data[5] && r_asic_unlocked) begin
                            // unlocked asic: page toggle instead of mode write
                            n_asic_page_on = (r_in.data[4:3] == 2'b11);
                        end else begin
                            n_rom_mode      = r_in.data[3:0];
                            n_out.irq_clear = r_in.data[4];
                        end
                    end
                    GA_RAM: begin
                        // base machine ignores banking; 128K has no block select
                        n_ram_config = (r_ram_expansion != 2'd0) ? r_in.data[2:0] : 3'd0;
                        n_ram_block  = r_ram_expansion[1] ? r_in.data[5:3] : 3'd0;
                    end
                    default: begin
                        n_ram_block = r_ram_block;
                    end
                endcase
            end
            FUNC_ROM_SEL: begin
                n_upper_rom_sel = r_in.data;
            end
            FUNC_MEM: begin
                n_out.source      = SRC_RAM;
                n_out.phys_offset = ram_offset;
                case (page)
                    2'd0: begin
                        if (r_in.is_write) begin
                            if (r_extra_rom && !lo_off) begin
                                n_out.source      = SRC_EXTRA_ROM;
                                n_out.phys_offset = rom_offset;
                            end
                        end else if (!lo_off) begin
                            n_out.source      = r_extra_rom ? SRC_EXTRA_ROM : SRC_LOWER_ROM;
                            n_out.phys_offset = rom_offset;
                        end
                    end
                    2'd1: begin
                        if (r_plus_model && r_asic_page_on) begin
                            n_out.source      = SRC_ASIC_PAGE;
                            n_out.phys_offset = rom_offset;
                        end
                    end
                    2'd3: begin
                        if (!r_in.is_write && !hi_off) begin
                            n_out.source      = SRC_UPPER_ROM;
                            n_out.phys_offset = rom_offset;
                        end
                    end
                    default: begin
                        n_out.source = SRC_RAM;
                    end
                endcase
            end
            FUNC_TICK: begin
                // commit pending colour to the selected pen
                if (r_pending_valid) begin
                    n_out.ink_write   = 1'b1;
                    n_out.ink_pen     = r_pen_select;
                    n_out.ink_colour  = r_pending_colour;
                    n_pending_valid   = 1'b0;
                end
            end
            default: begin
                n_out.source = SRC_RAM;
            end
        endcase

        // status reflects state after this transaction
        if ({1'b0, n_upper_rom_sel} >= SLOT_LIMIT) begin
            n_out.rom_slot = 4'd0;
        end else begin
            n_out.rom_slot = n_upper_rom_sel[3:0];
        end
        n_out.screen_mode = n_rom_mode[1:0];
    end

    // gate array state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_select     <= 5'd0;
            r_pending_valid  <= 1'b0;
            r_pending_colour <= 5'd0;
            r_rom_mode       <= ROM_MODE_RESET;
            r_ram_config     <= 3'd0;
            r_ram_block      <= 3'd0;
            r_asic_page_on   <= 1'b0;
            r_upper_rom_sel  <= 8'd0;
        end else if (advance) begin
            r_pen_select     <= n_pen_select;
            r_pending_valid  <= n_pending_valid;
            r_pending_colour <= n_pending_colour;
            r_rom_mode       <= n_rom_mode;
            r_ram_config     <= n_ram_config;
            r_ram_block      <= n_ram_block;
            r_asic_page_on   <= n_asic_page_on;
            r_upper_rom_sel  <= n_upper_rom_sel;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // nothing in flight right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    // rom and asic offsets stay within one 16K page
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_result.source != SRC_RAM |-> o_out_result.phys_offset[19:14] == 6'd0)
        else $error("non-ram offset beyond 16K");

    // selected pen never goes past the border
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_pen_select <= BORDER_PEN)
        else $error("pen select out of range");

    // a committing tick consumes the pending colour
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.func == FUNC_TICK |=> !r_pending_valid && o_out_valid)
        else $error("pending colour survived a tick");
`endif

endmodule
